// File: hdl/qjt_pkg.sv
// Shared types, constants and helpers for the quintic joint trajectory block.
// Holds the word formats, the micro-op program and the fixed-point saturation helpers.
// No dependencies.
package qjt_pkg;

  localparam int W    = 48;
  localparam int MAGW = 96;
  localparam int PC_W = 6;

  typedef struct packed {
    logic              func;
    logic [2:0]        joint;
    logic signed [W-1:0] now_time;
    logic signed [W-1:0] start_time;
    logic signed [W-1:0] start_pos;
    logic signed [W-1:0] start_vel;
    logic signed [W-1:0] start_acc;
    logic signed [W-1:0] end_time;
    logic signed [W-1:0] end_pos;
    logic signed [W-1:0] end_vel;
    logic signed [W-1:0] end_acc;
  } cmd_word_t;

  typedef struct packed {
    logic signed [W-1:0] position;
    logic [1:0]          status;
  } rsp_word_t;

  localparam logic FUNC_PLAN   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  localparam logic [1:0] ST_SAMPLE_OK  = 2'd0;
  localparam logic [1:0] ST_PLAN_OK    = 2'd1;
  localparam logic [1:0] ST_PLAN_REJ   = 2'd2;
  localparam logic [1:0] ST_SATURATED  = 2'd3;

  typedef enum logic [2:0] {
    OP_MOV, OP_ADD, OP_SUB, OP_SCL, OP_MUL, OP_DIV, OP_HALF
  } op_e;

  // operand codes: temps, coefficients of the addressed joint, input fields
  typedef logic [4:0] opnd_t;
  localparam opnd_t T0 = 5'd0;
  localparam opnd_t T1 = 5'd1;
  localparam opnd_t T2 = 5'd2;
  localparam opnd_t T3 = 5'd3;
  localparam opnd_t T4 = 5'd4;
  localparam opnd_t T5 = 5'd5;
  localparam opnd_t C0 = 5'd8;
  localparam opnd_t C1 = 5'd9;
  localparam opnd_t C2 = 5'd10;
  localparam opnd_t C3 = 5'd11;
  localparam opnd_t C4 = 5'd12;
  localparam opnd_t C5 = 5'd13;
  localparam opnd_t I_NOW = 5'd16;
  localparam opnd_t I_ST  = 5'd17;
  localparam opnd_t I_SP  = 5'd18;
  localparam opnd_t I_VS  = 5'd19;
  localparam opnd_t I_AS  = 5'd20;
  localparam opnd_t I_ET  = 5'd21;
  localparam opnd_t I_EP  = 5'd22;
  localparam opnd_t I_VF  = 5'd23;
  localparam opnd_t I_AF  = 5'd24;

  typedef struct packed {
    op_e               op;
    opnd_t             dst;
    opnd_t             a;
    opnd_t             b;
    logic signed [6:0] k;
  } instr_t;

  localparam logic [PC_W-1:0] PLAN_PC0  = 6'd0;
  localparam logic [PC_W-1:0] PLAN_LAST = 6'd49;
  localparam logic [PC_W-1:0] SAMP_PC0  = 6'd50;
  localparam logic [PC_W-1:0] SAMP_LAST = 6'd61;

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_ISSUE, S_START, S_WAIT, S_WB, S_FINISH
  } state_e;

  typedef struct packed {
    logic   load;
    logic   start;
    logic   write;
    logic   commit;
    logic   emit;
    instr_t instr;
  } dp_cmd_t;

  typedef struct packed {
    logic bad;
    logic busy;
    logic out_hold;
    logic func;
  } dp_stat_t;

  typedef struct packed {
    logic              sat;
    logic signed [W-1:0] val;
  } sres_t;

  function automatic instr_t mk(op_e op, opnd_t dst, opnd_t a, opnd_t b,
                                logic signed [6:0] k);
    instr_t i;
    i.op = op; i.dst = dst; i.a = a; i.b = b; i.k = k;
    return i;
  endfunction

  // micro-op program: plan 0..49, sample 50..61
  function automatic instr_t rom(logic [PC_W-1:0] pc);
    instr_t i;
    unique case (pc)
      6'd0:  i = mk(OP_SUB,  T0, I_ET, I_ST, 7'sd0);
      6'd1:  i = mk(OP_SUB,  T1, I_EP, I_SP, 7'sd0);
      6'd2:  i = mk(OP_MUL,  T2, T0,   T0,   7'sd0);
      6'd3:  i = mk(OP_SCL,  T3, T1,   T1,   7'sd20);
      6'd4:  i = mk(OP_SCL,  T4, I_VF, I_VF, 7'sd8);
      6'd5:  i = mk(OP_SCL,  T5, I_VS, I_VS, 7'sd12);
      6'd6:  i = mk(OP_ADD,  T4, T4,   T5,   7'sd0);
      6'd7:  i = mk(OP_MUL,  T4, T4,   T0,   7'sd0);
      6'd8:  i = mk(OP_SUB,  T3, T3,   T4,   7'sd0);
      6'd9:  i = mk(OP_SCL,  T4, I_AS, I_AS, 7'sd3);
      6'd10: i = mk(OP_SUB,  T4, T4,   I_AF, 7'sd0);
      6'd11: i = mk(OP_MUL,  T4, T4,   T2,   7'sd0);
      6'd12: i = mk(OP_SUB,  T3, T3,   T4,   7'sd0);
      6'd13: i = mk(OP_DIV,  T3, T3,   T0,   7'sd0);
      6'd14: i = mk(OP_DIV,  T3, T3,   T0,   7'sd0);
      6'd15: i = mk(OP_DIV,  T3, T3,   T0,   7'sd0);
      6'd16: i = mk(OP_HALF, C3, T3,   T3,   7'sd0);
      6'd17: i = mk(OP_SCL,  T3, T1,   T1,   -7'sd30);
      6'd18: i = mk(OP_SCL,  T4, I_VF, I_VF, 7'sd14);
      6'd19: i = mk(OP_SCL,  T5, I_VS, I_VS, 7'sd16);
      6'd20: i = mk(OP_ADD,  T4, T4,   T5,   7'sd0);
      6'd21: i = mk(OP_MUL,  T4, T4,   T0,   7'sd0);
      6'd22: i = mk(OP_ADD,  T3, T3,   T4,   7'sd0);
      6'd23: i = mk(OP_SCL,  T4, I_AS, I_AS, 7'sd3);
      6'd24: i = mk(OP_SCL,  T5, I_AF, I_AF, 7'sd2);
      6'd25: i = mk(OP_SUB,  T4, T4,   T5,   7'sd0);
      6'd26: i = mk(OP_MUL,  T4, T4,   T2,   7'sd0);
      6'd27: i = mk(OP_ADD,  T3, T3,   T4,   7'sd0);
      6'd28: i = mk(OP_DIV,  T3, T3,   T0,   7'sd0);
      6'd29: i = mk(OP_DIV,  T3, T3,   T0,   7'sd0);
      6'd30: i = mk(OP_DIV,  T3, T3,   T0,   7'sd0);
      6'd31: i = mk(OP_DIV,  T3, T3,   T0,   7'sd0);
      6'd32: i = mk(OP_HALF, C4, T3,   T3,   7'sd0);
      6'd33: i = mk(OP_SCL,  T3, T1,   T1,   7'sd12);
      6'd34: i = mk(OP_ADD,  T4, I_VF, I_VS, 7'sd0);
      6'd35: i = mk(OP_SCL,  T4, T4,   T4,   7'sd6);
      6'd36: i = mk(OP_MUL,  T4, T4,   T0,   7'sd0);
      6'd37: i = mk(OP_SUB,  T3, T3,   T4,   7'sd0);
      6'd38: i = mk(OP_SUB,  T4, I_AF, I_AS, 7'sd0);
      6'd39: i = mk(OP_MUL,  T4, T4,   T2,   7'sd0);
      6'd40: i = mk(OP_ADD,  T3, T3,   T4,   7'sd0);
      6'd41: i = mk(OP_DIV,  T3, T3,   T0,   7'sd0);
      6'd42: i = mk(OP_DIV,  T3, T3,   T0,   7'sd0);
      6'd43: i = mk(OP_DIV,  T3, T3,   T0,   7'sd0);
      6'd44: i = mk(OP_DIV,  T3, T3,   T0,   7'sd0);
      6'd45: i = mk(OP_DIV,  T3, T3,   T0,   7'sd0);
      6'd46: i = mk(OP_HALF, C5, T3,   T3,   7'sd0);
      6'd47: i = mk(OP_MOV,  C0, I_SP, I_SP, 7'sd0);
      6'd48: i = mk(OP_MOV,  C1, I_VS, I_VS, 7'sd0);
      6'd49: i = mk(OP_HALF, C2, I_AS, I_AS, 7'sd0);
      6'd50: i = mk(OP_SUB,  T0, I_NOW, I_ST, 7'sd0);
      6'd51: i = mk(OP_MOV,  T1, C5,   C5,   7'sd0);
      6'd52: i = mk(OP_MUL,  T1, T1,   T0,   7'sd0);
      6'd53: i = mk(OP_ADD,  T1, C4,   T1,   7'sd0);
      6'd54: i = mk(OP_MUL,  T1, T1,   T0,   7'sd0);
      6'd55: i = mk(OP_ADD,  T1, C3,   T1,   7'sd0);
      6'd56: i = mk(OP_MUL,  T1, T1,   T0,   7'sd0);
      6'd57: i = mk(OP_ADD,  T1, C2,   T1,   7'sd0);
      6'd58: i = mk(OP_MUL,  T1, T1,   T0,   7'sd0);
      6'd59: i = mk(OP_ADD,  T1, C1,   T1,   7'sd0);
      6'd60: i = mk(OP_MUL,  T1, T1,   T0,   7'sd0);
      6'd61: i = mk(OP_ADD,  T1, C0,   T1,   7'sd0);
      default: i = mk(OP_MOV, T5, T5, T5, 7'sd0);
    endcase
    return i;
  endfunction

  function automatic logic [W-1:0] mag48(logic signed [W-1:0] x);
    return x[W-1] ? W'(-x) : W'(x);
  endfunction

  // clamp a wide signed value into the 48-bit range
  function automatic sres_t clamp64(logic signed [63:0] x);
    sres_t r;
    r.sat = 1'b0;
    if (x > 64'sh0000_7FFF_FFFF_FFFF) begin
      r.sat = 1'b1;
      r.val = 48'sh7FFF_FFFF_FFFF;
    end else if (x < -64'sh0000_8000_0000_0000) begin
      r.sat = 1'b1;
      r.val = 48'sh8000_0000_0000;
    end else begin
      r.val = W'(x);
    end
    return r;
  endfunction

  // sign and magnitude back to two's complement, saturating
  function automatic sres_t from_mag(logic neg, logic [MAGW-1:0] m);
    sres_t r;
    r.sat = 1'b0;
    if (neg) begin
      if (m > MAGW'(48'h8000_0000_0000)) begin
        r.sat = 1'b1;
        r.val = 48'sh8000_0000_0000;
      end else begin
        r.val = W'(48'd0 - m[W-1:0]);
      end
    end else begin
      if (m > MAGW'(48'h7FFF_FFFF_FFFF)) begin
        r.sat = 1'b1;
        r.val = 48'sh7FFF_FFFF_FFFF;
      end else begin
        r.val = m[W-1:0];
      end
    end
    return r;
  endfunction

endpackage

// File: hdl/qjt_ctrl.sv
// Sequencer for the quintic joint trajectory block.
// Steps the micro-op program and drives the datapath; uses qjt_pkg.
module qjt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  qjt_pkg::dp_stat_t stat,
  output qjt_pkg::dp_cmd_t  cmd
);

  qjt_pkg::state_e            state, state_next;
  logic [qjt_pkg::PC_W-1:0]   pc, pc_next;
  logic [qjt_pkg::PC_W-1:0]   last_pc;

  assign last_pc = (stat.func == qjt_pkg::FUNC_SAMPLE) ? qjt_pkg::SAMP_LAST
                                                        : qjt_pkg::PLAN_LAST;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qjt_pkg::S_IDLE;
      pc    <= '0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
    end
  end

  always_comb begin
    state_next = state;
    pc_next    = pc;
    unique case (state)
      qjt_pkg::S_IDLE:   if (cmd_valid) state_next = qjt_pkg::S_DECIDE;
      qjt_pkg::S_DECIDE: begin
        pc_next = (stat.func == qjt_pkg::FUNC_SAMPLE) ? qjt_pkg::SAMP_PC0
                                                       : qjt_pkg::PLAN_PC0;
        state_next = stat.bad ? qjt_pkg::S_FINISH : qjt_pkg::S_ISSUE;
      end
      qjt_pkg::S_ISSUE:  state_next = qjt_pkg::S_START;
      qjt_pkg::S_START:  state_next = qjt_pkg::S_WAIT;
      qjt_pkg::S_WAIT:   if (!stat.busy) state_next = qjt_pkg::S_WB;
      qjt_pkg::S_WB: begin
        pc_next    = pc + 1'b1;
        state_next = (pc == last_pc) ? qjt_pkg::S_FINISH : qjt_pkg::S_ISSUE;
      end
      qjt_pkg::S_FINISH: if (!stat.out_hold) state_next = qjt_pkg::S_IDLE;
      default:           state_next = qjt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready  = (state == qjt_pkg::S_IDLE);
    cmd.load   = (state == qjt_pkg::S_IDLE) && cmd_valid;
    cmd.start  = (state == qjt_pkg::S_START);
    cmd.write  = (state == qjt_pkg::S_WB);
    cmd.emit   = (state == qjt_pkg::S_FINISH) && !stat.out_hold;
    cmd.commit = cmd.emit && (stat.func == qjt_pkg::FUNC_PLAN) && !stat.bad;
    cmd.instr  = qjt_pkg::rom(pc);
  end

endmodule

// File: hdl/qjt_dp.sv
// Datapath of the quintic joint trajectory block: operand store, shared
// add/scale/multiply/divide unit and result register; uses qjt_pkg.
module qjt_dp #(
  parameter int JOINTS    = 7,
  parameter int FRAC_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  qjt_pkg::dp_cmd_t   cmd,
  output qjt_pkg::dp_stat_t  stat,
  input  qjt_pkg::cmd_word_t cmd_word,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output qjt_pkg::rsp_word_t rsp_word
);

  localparam int W     = qjt_pkg::W;
  localparam int NUMW  = W + FRAC_BITS;
  localparam int CW    = $clog2(NUMW + 1);
  localparam int DEPTH = 8 * (JOINTS + 1);
  localparam int AW    = $clog2(DEPTH);
  localparam int JIW   = (JOINTS > 1) ? $clog2(JOINTS) : 1;

  qjt_pkg::cmd_word_t in_q;
  logic               jvalid [JOINTS];
  logic [W-1:0]       rf [DEPTH];
  logic [W-1:0]       rd_a, rd_b;

  qjt_pkg::op_e        op_q;
  logic signed [6:0]   k_q;
  logic signed [W-1:0] a_q, b_q;
  logic [W-1:0]        xm, ym;
  logic                neg_q;
  logic                busy;
  logic [CW-1:0]       cnt;
  logic [95:0]         acc;
  logic [W-1:0]        rem;
  logic [NUMW-1:0]     nq;
  logic signed [W-1:0] res_q;
  logic                sat;

  logic signed [W:0]   span;
  logic                bad;
  logic                jv;
  logic signed [W-1:0] opa, opb;
  logic [AW-1:0]       ra_addr, rb_addr, w_addr;

  function automatic logic [AW-1:0] addr_of(qjt_pkg::opnd_t c, logic [2:0] j);
    logic [31:0] a;
    a = c[3] ? (((32'(j) + 32'd1) << 3) | 32'(c[2:0])) : 32'(c[2:0]);
    return AW'(a);
  endfunction

  function automatic logic signed [W-1:0] pick(qjt_pkg::opnd_t c, logic [W-1:0] rd,
                                               qjt_pkg::cmd_word_t q, logic v);
    logic signed [W-1:0] r;
    r = rd;
    if (c[4]) begin
      unique case (c)
        qjt_pkg::I_NOW: r = q.now_time;
        qjt_pkg::I_ST:  r = q.start_time;
        qjt_pkg::I_SP:  r = q.start_pos;
        qjt_pkg::I_VS:  r = q.start_vel;
        qjt_pkg::I_AS:  r = q.start_acc;
        qjt_pkg::I_ET:  r = q.end_time;
        qjt_pkg::I_EP:  r = q.end_pos;
        qjt_pkg::I_VF:  r = q.end_vel;
        qjt_pkg::I_AF:  r = q.end_acc;
        default:        r = '0;
      endcase
    end else if (c[3] && !v) begin
      r = '0;  // joint never planned: coefficients read as zero
    end
    return r;
  endfunction

  // rejection check
  assign span = {in_q.end_time[W-1], in_q.end_time} - {in_q.start_time[W-1], in_q.start_time};
  assign bad  = (32'(in_q.joint) >= JOINTS) ||
                ((in_q.func == qjt_pkg::FUNC_PLAN) && (span[W] || (span == '0)));
  assign jv   = jvalid[JIW'(in_q.joint)];

  assign ra_addr = addr_of(cmd.instr.a, in_q.joint);
  assign rb_addr = addr_of(cmd.instr.b, in_q.joint);
  assign w_addr  = addr_of(cmd.instr.dst, in_q.joint);
  assign opa     = pick(cmd.instr.a, rd_a, in_q, jv);
  assign opb     = pick(cmd.instr.b, rd_b, in_q, jv);

  // operand store
  always_ff @(posedge clk) begin
    if (cmd.write && !cmd.instr.dst[4]) begin
      rf[w_addr] <= res_q;
    end
    rd_a <= rf[ra_addr];
    rd_b <= rf[rb_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_q <= cmd_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < JOINTS; j++) jvalid[j] <= 1'b0;
    end else if (cmd.commit) begin
      jvalid[JIW'(in_q.joint)] <= 1'b1;
    end
  end

  // shared arithmetic unit
  logic [23:0]          xs, ys;
  logic [47:0]          pp;
  logic [95:0]          pp_sh;
  logic [95:0]          mul_rnd;
  logic [W:0]           t49;
  logic                 ge;
  logic [NUMW:0]        qr;
  logic                 rb;
  logic signed [W+6:0]  scl;
  logic [W:0]           hm;
  qjt_pkg::sres_t       simple_r, mul_r, div_r;

  always_comb begin
    xs = cnt[1] ? xm[47:24] : xm[23:0];
    ys = cnt[0] ? ym[47:24] : ym[23:0];
    pp = xs * ys;
    unique case ({1'b0, cnt[1]} + {1'b0, cnt[0]})
      2'd0:    pp_sh = 96'(pp);
      2'd1:    pp_sh = 96'(pp) << 24;
      default: pp_sh = 96'(pp) << 48;
    endcase
    mul_rnd = (acc + (96'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    mul_r   = qjt_pkg::from_mag(neg_q, mul_rnd);

    t49 = {rem, nq[NUMW-1]};
    ge  = (t49 >= {1'b0, ym});
    rb  = ({1'b0, rem} >= ({1'b0, ym} - {1'b0, rem}));
    qr  = {1'b0, nq} + (NUMW + 1)'(rb);
    div_r = qjt_pkg::from_mag(neg_q, qjt_pkg::MAGW'(qr));

    scl = a_q * k_q;
    hm  = ({1'b0, xm} + 49'd1) >> 1;
    unique case (op_q)
      qjt_pkg::OP_ADD:  simple_r = qjt_pkg::clamp64(64'(a_q) + 64'(b_q));
      qjt_pkg::OP_SUB:  simple_r = qjt_pkg::clamp64(64'(a_q) - 64'(b_q));
      qjt_pkg::OP_SCL:  simple_r = qjt_pkg::clamp64(64'(scl));
      qjt_pkg::OP_HALF: begin
        simple_r.sat = 1'b0;
        simple_r.val = a_q[W-1] ? W'(-hm) : W'(hm);
      end
      default: begin
        simple_r.sat = 1'b0;
        simple_r.val = a_q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      sat  <= 1'b0;
    end else if (cmd.load) begin
      sat <= 1'b0;
    end else if (cmd.start) begin
      busy  <= 1'b1;
      cnt   <= '0;
      op_q  <= cmd.instr.op;
      k_q   <= cmd.instr.k;
      a_q   <= opa;
      b_q   <= opb;
      xm    <= qjt_pkg::mag48(opa);
      ym    <= qjt_pkg::mag48(opb);
      neg_q <= opa[W-1] ^ opb[W-1];
      acc   <= '0;
      rem   <= '0;
      nq    <= NUMW'(qjt_pkg::mag48(opa)) << FRAC_BITS;
    end else if (busy) begin
      priority case (op_q)
        qjt_pkg::OP_MUL: begin
          if (cnt < CW'(4)) begin
            acc <= acc + pp_sh;
            cnt <= cnt + 1'b1;
          end else begin
            res_q <= mul_r.val;
            sat   <= sat | mul_r.sat;
            busy  <= 1'b0;
          end
        end
        qjt_pkg::OP_DIV: begin
          if (cnt < CW'(NUMW)) begin
            rem <= ge ? W'(t49 - {1'b0, ym}) : t49[W-1:0];
            nq  <= {nq[NUMW-2:0], ge};
            cnt <= cnt + 1'b1;
          end else begin
            res_q <= div_r.val;
            sat   <= sat | div_r.sat;
            busy  <= 1'b0;
          end
        end
        default: begin
          res_q <= simple_r.val;
          sat   <= sat | simple_r.sat;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (in_q.func == qjt_pkg::FUNC_PLAN) begin
        rsp_word.position <= '0;
        rsp_word.status   <= bad ? qjt_pkg::ST_PLAN_REJ :
                             (sat ? qjt_pkg::ST_SATURATED : qjt_pkg::ST_PLAN_OK);
      end else begin
        rsp_word.position <= bad ? '0 : res_q;
        rsp_word.status   <= (!bad && sat) ? qjt_pkg::ST_SATURATED
                                           : qjt_pkg::ST_SAMPLE_OK;
      end
    end
  end

  assign stat.bad      = bad;
  assign stat.busy     = busy;
  assign stat.out_hold = rsp_valid && !rsp_ready;
  assign stat.func     = in_q.func;

endmodule

// File: hdl/quintic_joint_trajectory.sv
// Quintic joint trajectory generator, top level.
// Joins the sequencer qjt_ctrl and the datapath qjt_dp; uses qjt_pkg.
//
// One word in, one word out. A plan word (func 0) derives the six quintic
// coefficients for its joint from the segment duration and boundary
// conditions and stores them; a sample word (func 1) evaluates the stored
// polynomial at now_time - start_time. All values are signed Q15.32 with
// saturation; status 3 flags any saturated step. A plan with a non-positive
// duration or a joint index at or above JOINTS is rejected with status 2 and
// leaves the coefficients alone. Words are handled one at a time by a micro-op
// sequencer over one shared arithmetic unit: a multiply sums four 24x24
// partial products and then rounds, a divide is a restoring divider with
// one quotient bit per cycle, and a plan's run is dominated by its twelve
// divisions. The next word is taken while the previous result waits in the
// output register. Coefficients of a joint read as zero until its first
// accepted plan.
module quintic_joint_trajectory #(
  parameter int JOINTS    = 7,
  parameter int FRAC_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  qjt_pkg::cmd_word_t cmd_word,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output qjt_pkg::rsp_word_t rsp_word
);

  qjt_pkg::dp_cmd_t  cmd;
  qjt_pkg::dp_stat_t stat;

  // sequencer: owns the program counter and the handshake timing
  qjt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: operand store, coefficient store, arithmetic, result register
  qjt_dp #(
    .JOINTS    (JOINTS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cmd_word  (cmd_word),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_word  (rsp_word)
  );

  // a result appears only when the sequencer releases one
  a_emit_only: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(cmd.emit))
    else $error("result word without release");

  // a new word is never taken while the arithmetic unit is running
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_ready |-> !stat.busy)
    else $error("ready while unit busy");

  // no op is started on top of a running one
  a_start_free: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> !stat.busy)
    else $error("start while unit busy");

  // coefficients are marked valid only by an accepted plan
  a_commit_plan: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (stat.func == qjt_pkg::FUNC_PLAN) && !stat.bad)
    else $error("commit for rejected or sample word");

endmodule
